// File: rtl/lfb_pkg.sv
`default_nettype none

package lfb_pkg;

    localparam int PCT_W     = 7;
    localparam int MS_W      = 16;
    localparam int DUTY_W    = 14;
    localparam int REQ_W     = 3;
    localparam int CFG_IDX_W = 3;
    localparam int PHASE_W   = 3;

    localparam int DUTY_FULL = 8192;
    localparam int PCT_FULL  = 100;

    localparam logic [PCT_W-1:0] PCT_MAX = PCT_W'(PCT_FULL);

    localparam logic [REQ_W-1:0] REQ_NONE      = 3'd0;
    localparam logic [REQ_W-1:0] REQ_SET_LEVEL = 3'd1;
    localparam logic [REQ_W-1:0] REQ_ON        = 3'd2;
    localparam logic [REQ_W-1:0] REQ_OFF       = 3'd3;
    localparam logic [REQ_W-1:0] REQ_BREATH_ON = 3'd4;
    localparam logic [REQ_W-1:0] REQ_BREATH_OFF = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_FADE_STEP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ON_LEVEL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BREATH_LO  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BREATH_HI  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_STEP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_IN    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_STEP   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_OUT   = 3'd7;

    localparam logic [MS_W-1:0]  RST_FADE_STEP = 16'd50;
    localparam logic [PCT_W-1:0] RST_ON_LEVEL  = 7'd28;
    localparam logic [PCT_W-1:0] RST_BREATH_LO = 7'd22;
    localparam logic [PCT_W-1:0] RST_BREATH_HI = 7'd35;
    localparam logic [MS_W-1:0]  RST_IN_STEP   = 16'd153;
    localparam logic [MS_W-1:0]  RST_HOLD_IN   = 16'd1000;
    localparam logic [MS_W-1:0]  RST_OUT_STEP  = 16'd153;
    localparam logic [MS_W-1:0]  RST_HOLD_OUT  = 16'd2500;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [PCT_W-1:0] cmd_level;
        logic             pir_level;
    } t_in_req;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              relay_on;
        logic [PCT_W-1:0]  level;
        logic              breathing_active;
        logic              led_on;
    } t_out_res;

    typedef struct packed {
        logic [PCT_W-1:0] lo;
        logic [PCT_W-1:0] hi;
        logic [MS_W-1:0]  in_step;
        logic [MS_W-1:0]  hold_in;
        logic [MS_W-1:0]  out_step;
        logic [MS_W-1:0]  hold_out;
    } t_breath_cfg;

    typedef logic [PCT_FULL:0][DUTY_W-1:0] t_duty_tbl;

    function automatic logic [PCT_W-1:0] clamp100(input logic [PCT_W-1:0] v);
        return (v > PCT_MAX) ? PCT_MAX : v;
    endfunction

    function automatic t_duty_tbl duty_table();
        t_duty_tbl tbl;
        for (int i = 0; i <= PCT_FULL; i++) begin
            tbl[i] = DUTY_W'((i * DUTY_FULL) / PCT_FULL);
        end
        return tbl;
    endfunction

    localparam t_duty_tbl DUTY_TBL = duty_table();

endpackage

`default_nettype wire

// File: rtl/lfb_breath.sv
`default_nettype none

module lfb_breath (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_tick,
    input  wire logic                       i_en,
    input  wire lfb_pkg::t_breath_cfg       i_cfg,
    output logic                            o_active,
    output logic [lfb_pkg::PCT_W-1:0]       o_pct
);
    import lfb_pkg::*;

    localparam logic [PHASE_W-1:0] PH_IDLE     = 3'd0;
    localparam logic [PHASE_W-1:0] PH_UP       = 3'd1;
    localparam logic [PHASE_W-1:0] PH_HOLD_IN  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_DOWN     = 3'd3;
    localparam logic [PHASE_W-1:0] PH_HOLD_OUT = 3'd4;

    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [PCT_W-1:0]   r_duty, n_duty;
    logic [MS_W-1:0]    r_timer, n_timer;

    logic [PCT_W-1:0] lo, hi;
    logic [MS_W:0]    t_inc;

    always_comb begin
        lo      = clamp100(i_cfg.lo);
        hi      = clamp100(i_cfg.hi);
        t_inc   = {1'b0, r_timer} + (MS_W+1)'(1);
        n_phase = r_phase;
        n_duty  = r_duty;
        n_timer = r_timer;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_en) begin
                    n_phase = PH_UP;
                    n_duty  = lo;
                    n_timer = '0;
                end
            end
            PH_UP: begin
                n_timer = t_inc[MS_W-1:0];
                if (t_inc >= {1'b0, i_cfg.in_step}) begin
                    n_timer = '0;
                    if (r_duty < hi) begin
                        n_duty = r_duty + PCT_W'(1);
                    end else begin
                        n_phase = PH_HOLD_IN;
                    end
                end
            end
            PH_HOLD_IN: begin
                n_timer = t_inc[MS_W-1:0];
                if (t_inc >= {1'b0, i_cfg.hold_in}) begin
                    n_timer = '0;
                    n_phase = PH_DOWN;
                end
            end
            PH_DOWN: begin
                n_timer = t_inc[MS_W-1:0];
                if (t_inc >= {1'b0, i_cfg.out_step}) begin
                    n_timer = '0;
                    if (r_duty > lo) begin
                        n_duty = r_duty - PCT_W'(1);
                    end else begin
                        n_phase = PH_HOLD_OUT;
                    end
                end
            end
            PH_HOLD_OUT: begin
                n_timer = t_inc[MS_W-1:0];
                if (t_inc >= {1'b0, i_cfg.hold_out}) begin
                    n_timer = '0;
                    if (i_en) begin
                        n_phase = PH_UP;
                        n_duty  = lo;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_timer = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_duty  <= '0;
            r_timer <= '0;
        end else if (i_tick) begin
            r_phase <= n_phase;
            r_duty  <= n_duty;
            r_timer <= n_timer;
        end
    end

    assign o_active = (n_phase != PH_IDLE);
    assign o_pct    = n_duty;

endmodule

`default_nettype wire

// File: rtl/led_fade_breath_controller.sv
`default_nettype none

// Channel   Direction  Handshake                  Payload
// request   in         i_in_valid / o_in_stall    i_in_req  (t_in_req)
// result    out        o_out_valid / i_out_stall  o_out_res (t_out_res)
// config    in         i_cfg_we                   i_cfg_idx, i_cfg_data
//
// One request is taken every cycle while no stalled result holds the request register;
// a request is registered in the request register, then its result in the result register. Each tick's state
// update is a single pass of compare, increment and a duty table lookup.
// Synchronous active-low reset clears the valid flags and control state (not the request and result payload
// registers) and loads the default configuration. A stalled result holds in the result register while one more
// request waits in the request register.

module led_fade_breath_controller (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire lfb_pkg::t_in_req              i_in_req,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output lfb_pkg::t_out_res                  o_out_res,
    input  wire logic                          i_cfg_we,
    input  wire logic [lfb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [lfb_pkg::MS_W-1:0]      i_cfg_data
);
    import lfb_pkg::*;

    logic [MS_W-1:0]  r_fade_step;
    logic [PCT_W-1:0] r_on_level;
    logic [PCT_W-1:0] r_breath_lo;
    logic [PCT_W-1:0] r_breath_hi;
    logic [MS_W-1:0]  r_in_step;
    logic [MS_W-1:0]  r_hold_in;
    logic [MS_W-1:0]  r_out_step;
    logic [MS_W-1:0]  r_hold_out;

    t_in_req  r_in;
    logic     r_in_vld;
    t_out_res r_out, n_out;
    logic     r_out_vld;

    logic [PCT_W-1:0] r_cur, n_cur;
    logic [PCT_W-1:0] r_tgt, n_tgt;
    logic [MS_W-1:0]  r_ft, n_ft;
    logic             r_last_pir;
    logic             r_be, n_be;
    logic             r_relay, n_relay;

    logic             adv, fire, in_acc;
    logic [PCT_W-1:0] on_c;
    logic             cmd_rt, pir_rt, rt;
    logic [PCT_W-1:0] cmd_t, pir_t, new_t;
    logic [MS_W-1:0]  ft_a;
    logic [MS_W:0]    ft_inc;
    logic             b_active;
    logic [PCT_W-1:0] b_pct;
    logic [PCT_W-1:0] pct;
    t_breath_cfg      bcfg;

    assign adv        = !r_out_vld || !i_out_stall;
    assign fire       = r_in_vld && adv;
    assign o_in_stall = r_in_vld && !adv;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fade_step <= RST_FADE_STEP;
            r_on_level  <= RST_ON_LEVEL;
            r_breath_lo <= RST_BREATH_LO;
            r_breath_hi <= RST_BREATH_HI;
            r_in_step   <= RST_IN_STEP;
            r_hold_in   <= RST_HOLD_IN;
            r_out_step  <= RST_OUT_STEP;
            r_hold_out  <= RST_HOLD_OUT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FADE_STEP: r_fade_step <= i_cfg_data;
                CFG_ON_LEVEL:  r_on_level  <= i_cfg_data[PCT_W-1:0];
                CFG_BREATH_LO: r_breath_lo <= i_cfg_data[PCT_W-1:0];
                CFG_BREATH_HI: r_breath_hi <= i_cfg_data[PCT_W-1:0];
                CFG_IN_STEP:   r_in_step   <= i_cfg_data;
                CFG_HOLD_IN:   r_hold_in   <= i_cfg_data;
                CFG_OUT_STEP:  r_out_step  <= i_cfg_data;
                CFG_HOLD_OUT:  r_hold_out  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        bcfg.lo       = r_breath_lo;
        bcfg.hi       = r_breath_hi;
        bcfg.in_step  = r_in_step;
        bcfg.hold_in  = r_hold_in;
        bcfg.out_step = r_out_step;
        bcfg.hold_out = r_hold_out;
    end

    always_comb begin
        on_c   = clamp100(r_on_level);
        cmd_rt = 1'b0;
        cmd_t  = '0;
        n_be   = r_be;
        case (r_in.req_type)
            REQ_SET_LEVEL: begin
                cmd_rt = 1'b1;
                cmd_t  = clamp100(r_in.cmd_level);
            end
            REQ_ON: begin
                cmd_rt = 1'b1;
                cmd_t  = on_c;
            end
            REQ_OFF: begin
                cmd_rt = 1'b1;
            end
            REQ_BREATH_ON:  n_be = 1'b1;
            REQ_BREATH_OFF: n_be = 1'b0;
            default: ;
        endcase

        // A motion edge is applied after the command and may override its target.
        pir_rt = 1'b0;
        pir_t  = '0;
        if (r_in.pir_level != r_last_pir) begin
            if (r_in.pir_level) begin
                pir_rt = 1'b1;
            end else begin
                pir_rt = (r_cur < on_c);
                pir_t  = on_c;
            end
        end

        rt      = cmd_rt || pir_rt;
        new_t   = pir_rt ? pir_t : cmd_t;
        n_tgt   = rt ? new_t : r_tgt;
        ft_a    = rt ? '0 : r_ft;
        n_relay = r_relay;
        if (rt && (r_cur == '0)) begin
            n_relay = (new_t != '0);
        end

        ft_inc = {1'b0, ft_a} + (MS_W+1)'(1);
        n_cur  = r_cur;
        if (r_cur == n_tgt) begin
            n_ft = '0;
        end else if (ft_inc >= {1'b0, r_fade_step}) begin
            n_ft = '0;
            if (r_cur < n_tgt) begin
                n_cur = r_cur + PCT_W'(1);
            end else begin
                n_cur = r_cur - PCT_W'(1);
                if (r_cur == PCT_W'(1)) begin
                    n_relay = 1'b0;
                end
            end
        end else begin
            n_ft = ft_inc[MS_W-1:0];
        end
    end

    lfb_breath u_breath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tick   (fire),
        .i_en     (n_be),
        .i_cfg    (bcfg),
        .o_active (b_active),
        .o_pct    (b_pct)
    );

    always_comb begin
        pct                    = b_active ? b_pct : n_cur;
        n_out.duty             = DUTY_TBL[pct];
        n_out.relay_on         = n_relay;
        n_out.level            = n_cur;
        n_out.breathing_active = b_active;
        n_out.led_on           = (n_cur != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
            r_cur      <= '0;
            r_tgt      <= '0;
            r_ft       <= '0;
            r_last_pir <= 1'b1;
            r_be       <= 1'b0;
            r_relay    <= 1'b0;
        end else begin
            if (in_acc) begin
                r_in_vld <= 1'b1;
            end else if (fire) begin
                r_in_vld <= 1'b0;
            end
            if (fire) begin
                r_out_vld  <= 1'b1;
                r_cur      <= n_cur;
                r_tgt      <= n_tgt;
                r_ft       <= n_ft;
                r_last_pir <= r_in.pir_level;
                r_be       <= n_be;
                r_relay    <= n_relay;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in_req;
        end
        if (fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_res   = r_out;

endmodule

`default_nettype wire
